/* rtl/fqmtf_pkg.sv */
`default_nettype none

package fqmtf_pkg;

  // operation codes carried in func
  localparam logic [1:0] FUNC_ENQ   = 2'd0;
  localparam logic [1:0] FUNC_DEQ   = 2'd1;
  localparam logic [1:0] FUNC_MOVE  = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // front value reported for an empty queue
  localparam logic signed [31:0] FRONT_NONE = -32'sd1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [4:0]         position;
  } fqmtf_in_t;

  typedef struct packed {
    logic signed [31:0] dequeued_value;
    logic               dequeued_valid;
    logic signed [31:0] front_value;
    logic [4:0]         queue_length;
    logic [1:0]         status;
  } fqmtf_out_t;

endpackage

`default_nettype wire

/* rtl/fqmtf_ram.sv */
`default_nettype none

// Entry store: one write port, one read port, registered read data.
module fqmtf_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/fifo_queue_move_to_front.sv */
`default_nettype none

// Bounded FIFO of signed 32-bit words with a move-to-front operation. Each input
// word carries one operation (enqueue, dequeue, move the element at a 1-based
// position to the head, or query) and yields exactly one result word with the
// removed value, the head value after the operation (-1 when empty), the length
// and a status. Entries live in a single-read, single-write RAM addressed as a
// circular buffer. One operation is in flight at a time: enqueue, query, a move
// of position 1 and every rejected operation go straight to the result word, a
// dequeue that leaves the queue non-empty first re-reads the new head from the
// RAM, and a move of position p >= 2 shifts the elements ahead of it back one
// RAM access per cycle. The input is taken again as soon as the previous result
// sits in the output register.
module fifo_queue_move_to_front #(
  parameter int DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire fqmtf_pkg::fqmtf_in_t    in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output fqmtf_pkg::fqmtf_out_t        out_data
);

  import fqmtf_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > 5) ? CW : 5) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DQ_FRONT,
    S_MV_FIRST,
    S_MV_SHIFT,
    S_MV_PUT,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [31:0]        front_r, front_nxt;
  logic [31:0]        moved_r, moved_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [31:0]        deq_r, deq_nxt;
  logic               deq_ok_r, deq_ok_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  fqmtf_out_t         out_r, out_nxt;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  logic               accept;
  logic [WW-1:0]      pos_w;
  logic [WW-1:0]      cnt_w;
  logic [WW-1:0]      k_w;

  // circular slot of the element at offset off from the head
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] head,
                                         input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IW + 1)'(DEPTH)) begin
      sum = sum - (IW + 1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  fqmtf_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // position checks in a width that holds both the field and the count
  assign pos_w = WW'(in_data.position);
  assign cnt_w = WW'(count_r);
  assign k_w   = pos_w - WW'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    moved_nxt     = moved_r;
    idx_nxt       = idx_r;
    deq_nxt       = deq_r;
    deq_ok_nxt    = deq_ok_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = slot(head_r, idx_r);
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = slot(head_r, idx_r);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          deq_nxt    = '0;
          deq_ok_nxt = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
          case (in_data.func)
            FUNC_ENQ: begin
              if (cnt_w == WW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = slot(head_r, count_r[IW-1:0]);
                wr_data   = in_data.value;
                count_nxt = count_r + CW'(1);
                if (count_r == '0) begin
                  front_nxt = in_data.value;
                end
              end
            end
            FUNC_DEQ: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                deq_nxt    = front_r;
                deq_ok_nxt = 1'b1;
                head_nxt   = slot(head_r, IW'(1));
                count_nxt  = count_r - CW'(1);
                // fetch the new head unless the queue runs empty
                if (count_r != CW'(1)) begin
                  rd_en     = 1'b1;
                  rd_addr   = slot(head_r, IW'(1));
                  state_nxt = S_DQ_FRONT;
                end
              end
            end
            FUNC_MOVE: begin
              if (pos_w == '0 || pos_w > cnt_w) begin
                status_nxt = ST_BADPOS;
              end else if (k_w != '0) begin
                idx_nxt   = k_w[IW-1:0];
                rd_en     = 1'b1;
                rd_addr   = slot(head_r, k_w[IW-1:0]);
                state_nxt = S_MV_FIRST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_DQ_FRONT: begin
        front_nxt = rd_data;
        state_nxt = S_DONE;
      end

      // rd_data holds the element being moved; fetch its predecessor
      S_MV_FIRST: begin
        moved_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = slot(head_r, idx_r - IW'(1));
        state_nxt = S_MV_SHIFT;
      end

      // shift one element back per cycle, reading the next one ahead
      S_MV_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = slot(head_r, idx_r);
        wr_data = rd_data;
        idx_nxt = idx_r - IW'(1);
        if (idx_r == IW'(1)) begin
          state_nxt = S_MV_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot(head_r, idx_r - IW'(1) - IW'(1));
        end
      end

      S_MV_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = moved_r;
        front_nxt = moved_r;
        state_nxt = S_DONE;
      end

      // load the result word once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_nxt.dequeued_value = deq_r;
          out_nxt.dequeued_valid = deq_ok_r;
          out_nxt.front_value    = (count_r == '0) ? FRONT_NONE : front_r;
          out_nxt.queue_length   = cnt_w[4:0];
          out_nxt.status         = status_r;
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    front_r  <= front_nxt;
    moved_r  <= moved_nxt;
    idx_r    <= idx_nxt;
    deq_r    <= deq_nxt;
    deq_ok_r <= deq_ok_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire
